// File: design/sclt_pkg.sv
// shared types and constants of the command line tokenizer
package sclt_pkg;

    localparam int MAX_ARGS     = 32;
    localparam int MAX_ARG_LEN  = 32;
    localparam int MAX_COMMANDS = 16;
    localparam int MAX_NAME_LEN = 32;

    // line state widths hold the limit itself
    localparam int CMD_W  = $clog2(MAX_COMMANDS + 1);
    localparam int ARGS_W = $clog2(MAX_ARGS + 1);
    localparam int TOK_W  = $clog2(MAX_ARG_LEN + 1);
    localparam int NAME_W = $clog2(MAX_NAME_LEN + 1);

    // result field widths
    localparam int CMD_IDX_W = 4;
    localparam int ARG_IDX_W = 5;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_GT,
        MODE_NBLANK,
        MODE_NAME,
        MODE_DISCARD
    } mode_t;

    typedef enum logic [2:0] {
        EV_ARG_CHAR  = 3'd0,
        EV_ARG_END   = 3'd1,
        EV_NAME_CHAR = 3'd2,
        EV_REDIR_END = 3'd3,
        EV_CMD_END   = 3'd4,
        EV_LINE_END  = 3'd5,
        EV_ERROR     = 3'd6
    } ev_kind_t;

    typedef enum logic [1:0] {
        ERR_TOO_MANY_ARGS = 2'd0,
        ERR_ARG_TOO_LONG  = 2'd1,
        ERR_TOO_MANY_CMDS = 2'd2,
        ERR_NAME_TOO_LONG = 2'd3
    } err_code_t;

    typedef struct packed {
        ev_kind_t               kind;
        logic [7:0]             char_out;
        logic [CMD_IDX_W-1:0]   command_index;
        logic [ARG_IDX_W-1:0]   arg_index;
        logic [POS_W-1:0]       position;
        logic [COUNT_W-1:0]     count;
        logic                   append;
        err_code_t              error_code;
    } ev_t;

    // all events caused by one byte
    typedef struct packed {
        logic [1:0]  n;
        ev_t [2:0]   ev;
    } grp_t;

    typedef struct packed {
        mode_t               mode;
        logic [CMD_W-1:0]    cmds;
        logic [ARGS_W-1:0]   args;
        logic [TOK_W-1:0]    tok;
        logic [NAME_W-1:0]   name_len;
        logic                append;
        logic                started;
    } line_state_t;

endpackage

// File: design/sclt_step.sv
// per-byte tokenizer logic: line state and byte in, next state and event group out
module sclt_step (
    input  sclt_pkg::line_state_t  cur,
    input  logic [7:0]             byte_in,
    output sclt_pkg::line_state_t  nxt,
    output sclt_pkg::grp_t         grp
);
    import sclt_pkg::*;

    line_state_t  st;
    ev_t [2:0]    evs;
    logic [1:0]   n;
    logic         skip;
    logic         do_normal;
    logic         fa_err;
    logic         blank;
    logic         name_ch;

    function automatic ev_t ev_make(ev_kind_t kind, logic [7:0] ch, line_state_t s,
                                    logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt,
                                    logic app, err_code_t err);
        ev_t e;
        e.kind          = kind;
        e.char_out      = ch;
        e.command_index = CMD_IDX_W'(s.cmds);
        e.arg_index     = ARG_IDX_W'(s.args);
        e.position      = pos;
        e.count         = cnt;
        e.append        = app;
        e.error_code    = err;
        return e;
    endfunction

    assign blank   = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
    assign name_ch = (byte_in >= 8'h61 && byte_in <= 8'h7A) ||
                     (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                     (byte_in >= 8'h30 && byte_in <= 8'h39) ||
                     byte_in == CH_DOT || byte_in == CH_UNDER ||
                     byte_in == CH_DASH || byte_in == CH_SLASH;

    always_comb begin
        st        = cur;
        evs       = '0;
        n         = 2'd0;
        skip      = 1'b0;
        do_normal = 1'b0;
        fa_err    = 1'b0;

        if (cur.mode == MODE_DISCARD) begin
            if (byte_in == CH_NUL) begin
                st = '0;
                st.mode = MODE_NORMAL;
            end
        end else begin
            if (byte_in != CH_NUL) begin
                st.started = 1'b1;
            end
            if (st.mode == MODE_GT) begin
                st.mode = MODE_NBLANK;
                if (byte_in == CH_GT) begin
                    st.append = 1'b1;
                    skip = 1'b1;
                end else begin
                    st.append = 1'b0;
                end
            end

            if (!skip) begin
                if (st.mode == MODE_NBLANK || st.mode == MODE_NAME) begin
                    if (st.mode == MODE_NBLANK && blank) begin
                        // blanks before the name are dropped
                    end else if (name_ch) begin
                        st.mode = MODE_NAME;
                        evs[n] = ev_make(EV_NAME_CHAR, byte_in, st, POS_W'(st.name_len),
                                         '0, 1'b0, ERR_TOO_MANY_ARGS);
                        n = n + 2'd1;
                        st.name_len = st.name_len + NAME_W'(1);
                        if (st.name_len >= NAME_W'(MAX_NAME_LEN)) begin
                            evs[n] = ev_make(EV_ERROR, 8'h00, st, '0, '0, 1'b0,
                                             ERR_NAME_TOO_LONG);
                            n = n + 2'd1;
                            st.mode = MODE_DISCARD;
                        end
                    end else begin
                        // name ends; the byte is then taken as a normal byte
                        evs[n] = ev_make(EV_REDIR_END, 8'h00, st, '0,
                                         COUNT_W'(st.name_len), st.append, ERR_TOO_MANY_ARGS);
                        n = n + 2'd1;
                        st.name_len = '0;
                        st.mode = MODE_NORMAL;
                        do_normal = 1'b1;
                    end
                end else begin
                    do_normal = 1'b1;
                end
            end

            if (do_normal) begin
                if (byte_in == CH_NUL) begin
                    if (st.started) begin
                        if (st.tok != '0) begin
                            evs[n] = ev_make(EV_ARG_END, 8'h00, st, '0, COUNT_W'(st.tok),
                                             1'b0, ERR_TOO_MANY_ARGS);
                            n = n + 2'd1;
                            st.args = st.args + ARGS_W'(1);
                        end
                        evs[n] = ev_make(EV_CMD_END, 8'h00, st, '0, COUNT_W'(st.args),
                                         1'b0, ERR_TOO_MANY_ARGS);
                        n = n + 2'd1;
                        evs[n] = ev_make(EV_LINE_END, 8'h00, st, '0,
                                         COUNT_W'(st.cmds) + COUNT_W'(1), 1'b0,
                                         ERR_TOO_MANY_ARGS);
                        n = n + 2'd1;
                    end
                    st = '0;
                    st.mode = MODE_NORMAL;
                end else if (byte_in == CH_PIPE || byte_in == CH_GT || blank) begin
                    // close a pending argument
                    if (st.tok != '0) begin
                        evs[n] = ev_make(EV_ARG_END, 8'h00, st, '0, COUNT_W'(st.tok),
                                         1'b0, ERR_TOO_MANY_ARGS);
                        n = n + 2'd1;
                        st.args = st.args + ARGS_W'(1);
                        st.tok = '0;
                        if (st.args >= ARGS_W'(MAX_ARGS)) begin
                            evs[n] = ev_make(EV_ERROR, 8'h00, st, '0, '0, 1'b0,
                                             ERR_TOO_MANY_ARGS);
                            n = n + 2'd1;
                            st.mode = MODE_DISCARD;
                            fa_err = 1'b1;
                        end
                    end
                    if (!fa_err) begin
                        if (byte_in == CH_PIPE) begin
                            evs[n] = ev_make(EV_CMD_END, 8'h00, st, '0, COUNT_W'(st.args),
                                             1'b0, ERR_TOO_MANY_ARGS);
                            n = n + 2'd1;
                            st.cmds = st.cmds + CMD_W'(1);
                            st.args = '0;
                            if (st.cmds >= CMD_W'(MAX_COMMANDS)) begin
                                evs[n] = ev_make(EV_ERROR, 8'h00, st, '0, '0, 1'b0,
                                                 ERR_TOO_MANY_CMDS);
                                n = n + 2'd1;
                                st.mode = MODE_DISCARD;
                            end
                        end else if (byte_in == CH_GT) begin
                            st.name_len = '0;
                            st.mode = MODE_GT;
                        end
                    end
                end else begin
                    evs[n] = ev_make(EV_ARG_CHAR, byte_in, st, POS_W'(st.tok), '0,
                                     1'b0, ERR_TOO_MANY_ARGS);
                    n = n + 2'd1;
                    st.tok = st.tok + TOK_W'(1);
                    if (st.tok >= TOK_W'(MAX_ARG_LEN)) begin
                        evs[n] = ev_make(EV_ERROR, 8'h00, st, '0, '0, 1'b0,
                                         ERR_ARG_TOO_LONG);
                        n = n + 2'd1;
                        st.mode = MODE_DISCARD;
                    end
                end
            end
        end
    end

    assign nxt    = st;
    assign grp.n  = n;
    assign grp.ev = evs;

endmodule

// File: design/sclt_evq.sv
// two-entry queue of event groups, drained one event per output transfer
module sclt_evq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sclt_pkg::grp_t         wr_grp,
    output logic                   can_push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sclt_pkg::ev_t          out_ev,
    output logic                   out_last
);
    import sclt_pkg::*;

    grp_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  slot_reg, slot_next;
    grp_t        head;
    logic        xfer;
    logic        pop;

    assign head      = q_reg[rd_ptr_reg];
    assign out_valid = (cnt_reg != 2'd0);
    assign out_ev    = head.ev[slot_reg];
    assign out_last  = (slot_reg == head.n - 2'd1);
    assign can_push  = (cnt_reg != 2'd2);
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && out_last;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        slot_next   = slot_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (xfer) begin
            if (out_last) begin
                slot_next   = 2'd0;
                rd_ptr_next = ~rd_ptr_reg;
            end else begin
                slot_next = slot_reg + 2'd1;
            end
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            slot_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= wr_grp;
        end
    end

endmodule

// File: design/shell_command_line_tokenizer_top.sv
// top level of the shell command line tokenizer
// Takes one command line byte per transfer (zero ends the line) and emits token events, one
// per output transfer, with last set on the final event of each byte. A byte is held
// in the input register, where the tokenizer step turns it into up to three events written
// as one group into a two-entry group queue; a new byte is taken every cycle while the queue
// has room. With the output ready, sustained input is one byte per cycle for bytes with at most
// one event; a byte with more events needs a transfer per event, so the output sets the pace.
module shell_command_line_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_char_out,
    output logic [3:0]  m_command_index,
    output logic [4:0]  m_arg_index,
    output logic [4:0]  m_position,
    output logic [5:0]  m_count,
    output logic        m_append,
    output logic [1:0]  m_error_code,
    output logic        m_last
);
    import sclt_pkg::*;

    logic         in_vld_reg, in_vld_next;
    logic [7:0]   in_byte_reg;
    line_state_t  state_reg, state_next;
    grp_t         grp;
    logic         can_push;
    logic         process;
    ev_t          out_ev;

    sclt_step u_step (
        .cur     (state_reg),
        .byte_in (in_byte_reg),
        .nxt     (state_next),
        .grp     (grp)
    );

    assign process = in_vld_reg && can_push;
    assign s_ready = !in_vld_reg || process;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (process) begin
            in_vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (process) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
    end

    sclt_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (process && (grp.n != 2'd0)),
        .wr_grp    (grp),
        .can_push  (can_push),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_ev    (out_ev),
        .out_last  (m_last)
    );

    assign m_kind          = out_ev.kind;
    assign m_char_out      = out_ev.char_out;
    assign m_command_index = out_ev.command_index;
    assign m_arg_index     = out_ev.arg_index;
    assign m_position      = out_ev.position;
    assign m_count         = out_ev.count;
    assign m_append        = out_ev.append;
    assign m_error_code    = out_ev.error_code;

endmodule

// File: verif/tb.sv
// testbench of the command line tokenizer: predicts every token event and checks each transfer
module tb;
    import sclt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        ev_t  ev;
        logic last;
    } token_rec_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_char_out;
    logic [3:0] m_command_index;
    logic [4:0] m_arg_index;
    logic [4:0] m_position;
    logic [5:0] m_count;
    logic       m_append;
    logic [1:0] m_error_code;
    logic       m_last;

    shell_command_line_tokenizer_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_char_out      (m_char_out),
        .m_command_index (m_command_index),
        .m_arg_index     (m_arg_index),
        .m_position      (m_position),
        .m_count         (m_count),
        .m_append        (m_append),
        .m_error_code    (m_error_code),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // tokenizer line state as predicted
    mode_t tk_mode = MODE_NORMAL;
    int    tk_cmds = 0;
    int    tk_args = 0;
    int    tk_tok = 0;
    int    tk_name = 0;
    bit    tk_append = 1'b0;
    bit    tk_started = 1'b0;

    ev_t        byte_tokens[$];
    token_rec_t expected_tokens[$];

    int    mismatch_count = 0;
    int    bytes_fed = 0;
    int    stalled_cycles = 0;
    int    src_idle_pct = 0;
    int    sink_stall_pct = 0;
    string name_alphabet =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-/";

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic bit is_name_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
               b == CH_DOT || b == CH_UNDER || b == CH_DASH || b == CH_SLASH;
    endfunction

    function automatic void add_token(input ev_kind_t kind, input logic [7:0] ch, input int pos,
                                      input int cnt, input logic app, input err_code_t err);
        ev_t e;
        if (byte_tokens.size() >= 3)
            return;
        e.kind          = kind;
        e.char_out      = ch;
        e.command_index = tk_cmds[3:0];
        e.arg_index     = tk_args[4:0];
        e.position      = pos[4:0];
        e.count         = cnt[5:0];
        e.append        = app;
        e.error_code    = err;
        byte_tokens.push_back(e);
    endfunction

    function automatic void clear_line();
        tk_mode    = MODE_NORMAL;
        tk_cmds    = 0;
        tk_args    = 0;
        tk_tok     = 0;
        tk_name    = 0;
        tk_append  = 1'b0;
        tk_started = 1'b0;
    endfunction

    function automatic void raise_error(input err_code_t err);
        add_token(EV_ERROR, CH_NUL, 0, 0, 1'b0, err);
        tk_mode = MODE_DISCARD;
    endfunction

    // returns 1 when closing the argument hit the argument limit
    function automatic bit close_arg();
        if (tk_tok == 0)
            return 1'b0;
        add_token(EV_ARG_END, CH_NUL, 0, tk_tok, 1'b0, ERR_TOO_MANY_ARGS);
        tk_args++;
        tk_tok = 0;
        if (tk_args >= MAX_ARGS) begin
            raise_error(ERR_TOO_MANY_ARGS);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == CH_NUL) begin
            if (!tk_started) begin
                clear_line();
                return;
            end
            // no argument limit check at the line end
            if (tk_tok > 0) begin
                add_token(EV_ARG_END, CH_NUL, 0, tk_tok, 1'b0, ERR_TOO_MANY_ARGS);
                tk_args++;
                tk_tok = 0;
            end
            add_token(EV_CMD_END, CH_NUL, 0, tk_args, 1'b0, ERR_TOO_MANY_ARGS);
            add_token(EV_LINE_END, CH_NUL, 0, tk_cmds + 1, 1'b0, ERR_TOO_MANY_ARGS);
            clear_line();
        end else if (b == CH_PIPE) begin
            if (close_arg())
                return;
            add_token(EV_CMD_END, CH_NUL, 0, tk_args, 1'b0, ERR_TOO_MANY_ARGS);
            tk_cmds++;
            tk_args = 0;
            if (tk_cmds >= MAX_COMMANDS)
                raise_error(ERR_TOO_MANY_CMDS);
        end else if (b == CH_GT) begin
            if (close_arg())
                return;
            tk_name = 0;
            tk_mode = MODE_GT;
        end else if (is_blank(b)) begin
            void'(close_arg());
        end else begin
            add_token(EV_ARG_CHAR, b, tk_tok, 0, 1'b0, ERR_TOO_MANY_ARGS);
            tk_tok++;
            if (tk_tok >= MAX_ARG_LEN)
                raise_error(ERR_ARG_TOO_LONG);
        end
    endfunction

    function automatic void name_byte(input logic [7:0] b);
        add_token(EV_NAME_CHAR, b, tk_name, 0, 1'b0, ERR_TOO_MANY_ARGS);
        tk_name++;
        if (tk_name >= MAX_NAME_LEN)
            raise_error(ERR_NAME_TOO_LONG);
    endfunction

    function automatic void end_redirect();
        add_token(EV_REDIR_END, CH_NUL, 0, tk_name, tk_append, ERR_TOO_MANY_ARGS);
        tk_name = 0;
        tk_mode = MODE_NORMAL;
    endfunction

    function automatic void shell_step(input logic [7:0] b);
        if (tk_mode == MODE_DISCARD) begin
            if (b == CH_NUL)
                clear_line();
            return;
        end
        bytes_fed++;
        if (b != CH_NUL)
            tk_started = 1'b1;
        if (tk_mode == MODE_GT) begin
            tk_mode = MODE_NBLANK;
            if (b == CH_GT) begin
                tk_append = 1'b1;
                return;
            end
            tk_append = 1'b0;
        end
        if (tk_mode == MODE_NBLANK || tk_mode == MODE_NAME) begin
            if (tk_mode == MODE_NBLANK && is_blank(b)) begin
                // blanks before the name are skipped
            end else if (is_name_byte(b)) begin
                tk_mode = MODE_NAME;
                name_byte(b);
            end else begin
                // the byte that ends a name is then taken as a plain byte
                end_redirect();
                plain_byte(b);
            end
        end else begin
            plain_byte(b);
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        token_rec_t rec;
        byte_tokens.delete();
        shell_step(b);
        foreach (byte_tokens[i]) begin
            rec.ev   = byte_tokens[i];
            rec.last = (i == byte_tokens.size() - 1);
            expected_tokens.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        token_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result kind %0d with nothing expected", m_kind));
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind", m_kind, want.ev.kind);
                check_field("char_out", m_char_out, want.ev.char_out);
                check_field("command_index", m_command_index, want.ev.command_index);
                check_field("arg_index", m_arg_index, want.ev.arg_index);
                check_field("position", m_position, want.ev.position);
                check_field("count", m_count, want.ev.count);
                check_field("append", m_append, want.ev.append);
                check_field("error_code", m_error_code, want.ev.error_code);
                check_field("last", m_last, want.last);
            end
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        tokenize_byte(b);
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_tokens.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // mostly skips bytes that would only be discarded
    task automatic put_byte(input logic [7:0] b);
        if (tk_mode == MODE_DISCARD && $urandom_range(9) != 0)
            return;
        send_byte(b);
    endtask

    function automatic logic [7:0] rand_arg_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_PIPE || b == CH_GT || is_blank(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_name_byte();
        return name_alphabet[$urandom_range(name_alphabet.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic gen_line();
        int ncmd;
        int nargs;
        int alen;
        int nlen;
        if ($urandom_range(19) == 0) begin
            send_byte(CH_NUL);
            return;
        end
        ncmd = ($urandom_range(11) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 3);
        for (int c = 0; c < ncmd; c++) begin
            if ($urandom_range(3) == 0)
                put_byte(rand_blank());
            nargs = ($urandom_range(24) == 0) ? $urandom_range(30, 33) : $urandom_range(0, 4);
            for (int a = 0; a < nargs; a++) begin
                alen = ($urandom_range(19) == 0) ? $urandom_range(30, 33) : $urandom_range(1, 5);
                for (int k = 0; k < alen; k++)
                    put_byte(rand_arg_byte());
                if (a < nargs - 1 || $urandom_range(1))
                    put_byte(rand_blank());
            end
            if ($urandom_range(2) == 0) begin
                put_byte(CH_GT);
                if ($urandom_range(1))
                    put_byte(CH_GT);
                repeat ($urandom_range(2))
                    put_byte(rand_blank());
                nlen = ($urandom_range(14) == 0) ? $urandom_range(30, 33) : $urandom_range(0, 5);
                repeat (nlen)
                    put_byte(rand_name_byte());
                if ($urandom_range(1))
                    put_byte(rand_blank());
            end
            if ($urandom_range(9) == 0)
                put_byte(8'($urandom_range(255)));
            if (c < ncmd - 1)
                put_byte(CH_PIPE);
        end
        send_byte(CH_NUL);
    endtask

    task automatic test_basic_lines();
        set_idling(0, 0);
        send_byte(CH_NUL);
        send_text(" \t");
        send_byte(CH_NUL);
        // wide byte in an argument, append with blanks, name ended by a pipe, then >>>
        send_text("a");
        send_byte(8'hFF);
        send_text(">> f.|>>>z");
        send_byte(CH_NUL);
        send_text(">");
        send_byte(CH_NUL);
        send_text("|");
        send_byte(CH_NUL);
        wait_for_results();
    endtask

    task automatic test_arg_limits();
        set_idling(22, 22);
        repeat (MAX_ARGS) send_text("a ");
        send_text("xy|");
        send_byte(CH_NUL);
        // last argument closed by the line end itself
        repeat (MAX_ARGS - 1) send_text("b\t");
        send_text("c");
        send_byte(CH_NUL);
        repeat (MAX_ARG_LEN) send_text("q");
        send_text(" r");
        send_byte(CH_NUL);
        repeat (MAX_ARG_LEN - 1) send_text("w");
        send_byte(CH_NUL);
        wait_for_results();
    endtask

    task automatic test_pipeline_limits();
        set_idling(0, 74);
        repeat (MAX_COMMANDS) send_text("|");
        send_text("ab");
        send_byte(CH_NUL);
        repeat (MAX_COMMANDS - 1) send_text("p|");
        send_text("x");
        send_byte(CH_NUL);
        wait_for_results();
    endtask

    task automatic test_name_limits();
        set_idling(74, 0);
        send_text(">");
        repeat (MAX_NAME_LEN) send_text("n");
        send_text("k");
        send_byte(CH_NUL);
        send_text("x>>\t");
        repeat (MAX_NAME_LEN - 1) send_text("_");
        send_text(" y");
        send_byte(CH_NUL);
        wait_for_results();
    endtask

    task automatic test_random_lines(input int src_pct, input int sink_pct, input int target);
        int start;
        set_idling(src_pct, sink_pct);
        start = bytes_fed;
        while (bytes_fed - start < target)
            gen_line();
        wait_for_results();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_lines();
        test_arg_limits();
        test_pipeline_limits();
        test_name_limits();
        test_random_lines(0, 0, 30);
        test_random_lines(74, 0, 30);
        test_random_lines(0, 74, 30);
        test_random_lines(22, 22, 30);

        set_idling(0, 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_tokens.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
